>>> hw/rtl/srcr_pkg.sv
// srcr_pkg: shared widths, character codes, register map and reset values
// for the serial relay command receiver; no dependencies
package srcr_pkg;

	localparam int RX_BYTE_W     = 8;
	localparam int RELAY_OUT_W   = 6;
	localparam int CFG_W         = 8;
	localparam int APB_DATA_W    = 32;
	localparam int APB_ADDR_W    = 4;
	localparam int RELAY_COUNT_D = 6;

	// register indexes (byte address is 4 * index)
	localparam logic [1:0] REG_UNIT_ADDRESS = 2'd0;
	localparam logic [1:0] REG_WRITE_START  = 2'd1;
	localparam logic [1:0] REG_READ_START   = 2'd2;
	localparam logic [1:0] REG_TAIL         = 2'd3;

	localparam logic [CFG_W-1:0] UNIT_ADDRESS_RST = 8'd0;
	localparam logic [CFG_W-1:0] WRITE_START_RST  = 8'h57;
	localparam logic [CFG_W-1:0] READ_START_RST   = 8'h52;
	localparam logic [CFG_W-1:0] TAIL_RST         = 8'h0a;

	localparam logic [RX_BYTE_W-1:0] CHAR_SPACE = 8'h20;
	localparam logic [RX_BYTE_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [RX_BYTE_W-1:0] CHAR_ONE   = 8'h31;
	localparam logic [RX_BYTE_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [RX_BYTE_W-1:0] CHAR_LA    = 8'h61;
	localparam logic [RX_BYTE_W-1:0] CHAR_LF    = 8'h66;
	localparam logic [RX_BYTE_W-1:0] CHAR_UA    = 8'h41;
	localparam logic [RX_BYTE_W-1:0] CHAR_UF    = 8'h46;

	typedef enum logic [5:0] {
		PH_IDLE  = 6'b000001,
		PH_UNIT1 = 6'b000010,
		PH_UNIT2 = 6'b000100,
		PH_ADDR  = 6'b001000,
		PH_DATA  = 6'b010000,
		PH_TAIL  = 6'b100000
	} phase_t;

endpackage

>>> hw/rtl/srcr_rx_if.sv
// srcr_rx_if: valid/ready channel carrying one received character
// depends on srcr_pkg
interface srcr_rx_if import srcr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [RX_BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

>>> hw/rtl/srcr_res_if.sv
// srcr_res_if: valid/ready channel carrying one per-character result
// depends on srcr_pkg
interface srcr_res_if import srcr_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic [RELAY_OUT_W-1:0] relay_outputs;
	logic                   frame_active;
	logic                   frame_complete;
	logic                   frame_error;

	modport source (output valid, output relay_outputs, output frame_active,
		output frame_complete, output frame_error, input ready);
	modport sink (input valid, input relay_outputs, input frame_active,
		input frame_complete, input frame_error, output ready);
endinterface

>>> hw/rtl/serial_relay_command_receiver.sv
// serial_relay_command_receiver: frame parser and relay register block
// depends on srcr_pkg, srcr_rx_if, srcr_res_if
//
// usage
//   rx  : one received character per transfer (valid/ready)
//   res : one result per character: relay drive bits, frame activity,
//         frame complete and frame error flags (valid/ready)
//   apb : four 8-bit registers at byte addresses 0, 4, 8, 12: unit address,
//         write start char, read start char, tail char; pready is tied high
// frames are: start, two hex unit digits, address char, data char, tail;
// spaces are skipped, a start char restarts the frame from any phase
// path: a taken character is held in the input register, and its result
//   is registered in the output register once the output register frees
// throughput: one character per cycle while res takes its results; the
//   frame state is updated straight from the input register, so only res limits back-to-back use
// stall: when res is held off the output register keeps its result, the
//   input register still takes one more character if empty, then rx ready drops
// reset: relays off, parser idle, registers back to W, R and line feed,
//   unit address zero; both pipeline registers empty
module serial_relay_command_receiver import srcr_pkg::*; #(
	parameter int RELAY_COUNT = RELAY_COUNT_D
) (
	input  logic                  clk,
	input  logic                  arst_n,
	srcr_rx_if.sink               rx,
	srcr_res_if.source            res,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	// last valid address character for a relay command
	localparam logic [RX_BYTE_W-1:0] ADDR_LAST = 8'(int'(CHAR_ONE) + RELAY_COUNT - 1);

	// configuration registers
	logic [CFG_W-1:0] unit_address_q, write_start_q, read_start_q, tail_q;

	// input stage and output stage
	logic                 s1_valid_q;
	logic [RX_BYTE_W-1:0] rx_byte_s1;
	logic                 s2_valid_q;
	logic [RELAY_OUT_W-1:0] relay_out_s2;
	logic                 active_s2, complete_s2, error_s2;

	// parser state
	phase_t               phase_q, phase_n;
	logic [RX_BYTE_W-1:0] unit_hi_q, unit_lo_q, addr_q, data_q;
	logic [RELAY_COUNT-1:0] relay_q, relay_n;

	logic advance, step_en, cfg_wr;
	logic is_space, is_start, complete_n, error_n;
	logic [4:0] hex_hi, hex_lo;
	logic [RELAY_OUT_W-1:0] relay_out_n;

	// hex digit to {invalid, value}
	function automatic logic [4:0] hex_value(input logic [RX_BYTE_W-1:0] ch);
		logic [4:0] v;
		v = 5'h10;
		if (ch inside {[CHAR_ZERO:CHAR_NINE]}) v = 5'(ch - CHAR_ZERO);
		else if (ch inside {[CHAR_LA:CHAR_LF]}) v = 5'(ch - CHAR_LA + 8'd10);
		else if (ch inside {[CHAR_UA:CHAR_UF]}) v = 5'(ch - CHAR_UA + 8'd10);
		return v;
	endfunction

	// ---------------------------------------------------------------
	// apb register port
	// ---------------------------------------------------------------
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_address_q <= UNIT_ADDRESS_RST;
			write_start_q  <= WRITE_START_RST;
			read_start_q   <= READ_START_RST;
			tail_q         <= TAIL_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_UNIT_ADDRESS: unit_address_q <= pwdata[CFG_W-1:0];
				REG_WRITE_START:  write_start_q  <= pwdata[CFG_W-1:0];
				REG_READ_START:   read_start_q   <= pwdata[CFG_W-1:0];
				REG_TAIL:         tail_q         <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (paddr[3:2])
			REG_UNIT_ADDRESS: prdata[CFG_W-1:0] = unit_address_q;
			REG_WRITE_START:  prdata[CFG_W-1:0] = write_start_q;
			REG_READ_START:   prdata[CFG_W-1:0] = read_start_q;
			REG_TAIL:         prdata[CFG_W-1:0] = tail_q;
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// handshake: output register frees when empty or taken,
	// input register frees when its character moves on
	// ---------------------------------------------------------------
	assign advance  = !s2_valid_q || res.ready;
	assign step_en  = s1_valid_q && advance;
	assign rx.ready = !s1_valid_q || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (rx.ready) begin
			s1_valid_q <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			rx_byte_s1 <= rx.rx_byte;
		end
	end

	// ---------------------------------------------------------------
	// frame parser, one character per step
	// ---------------------------------------------------------------
	assign is_space = (rx_byte_s1 == CHAR_SPACE);
	// start wins over tail when both are configured to the same char
	assign is_start = (rx_byte_s1 == write_start_q) || (rx_byte_s1 == read_start_q);
	assign hex_hi   = hex_value(unit_hi_q);
	assign hex_lo   = hex_value(unit_lo_q);

	always_comb begin
		phase_n    = phase_q;
		relay_n    = relay_q;
		complete_n = 1'b0;
		error_n    = 1'b0;
		if (!is_space) begin
			if (is_start) begin
				phase_n = PH_UNIT1;
			end else begin
				case (phase_q)
					PH_UNIT1: phase_n = PH_UNIT2;
					PH_UNIT2: phase_n = PH_ADDR;
					PH_ADDR:  phase_n = PH_DATA;
					PH_DATA:  phase_n = PH_TAIL;
					PH_TAIL: begin
						phase_n = PH_IDLE;
						if (rx_byte_s1 == tail_q) begin
							complete_n = 1'b1;
							// non-hex unit digits match nothing, not even broadcast
							if (!hex_hi[4] && !hex_lo[4]) begin
								// unit zero, '0' '0': all relays off
								if ({hex_hi[3:0], hex_lo[3:0]} == 8'd0 &&
									addr_q == CHAR_ZERO && data_q == CHAR_ZERO) begin
									relay_n = '0;
								end
								if ({hex_hi[3:0], hex_lo[3:0]} == unit_address_q &&
									addr_q inside {[CHAR_ONE:ADDR_LAST]}) begin
									for (int i = 0; i < RELAY_COUNT; i++) begin
										if (addr_q == 8'(int'(CHAR_ONE) + i)) begin
											if (data_q == CHAR_ZERO) relay_n[i] = 1'b0;
											if (data_q == CHAR_ONE)  relay_n[i] = 1'b1;
										end
									end
								end
							end
						end else begin
							error_n = 1'b1;
						end
					end
					default: phase_n = PH_IDLE;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			relay_q   <= '0;
			unit_hi_q <= '0;
			unit_lo_q <= '0;
			addr_q    <= '0;
			data_q    <= '0;
		end else if (step_en) begin
			phase_q <= phase_n;
			relay_q <= relay_n;
			// character capture follows the phase it arrived in
			if (!is_space && !is_start) begin
				if (phase_q == PH_UNIT1) unit_hi_q <= rx_byte_s1;
				if (phase_q == PH_UNIT2) unit_lo_q <= rx_byte_s1;
				if (phase_q == PH_ADDR)  addr_q    <= rx_byte_s1;
				if (phase_q == PH_DATA)  data_q    <= rx_byte_s1;
			end
		end
	end

	// relays beyond the output width are kept but not driven out
	for (genvar g = 0; g < RELAY_OUT_W; g++) begin : g_relay_out
		if (g < RELAY_COUNT) begin : g_used
			assign relay_out_n[g] = relay_n[g];
		end else begin : g_unused
			assign relay_out_n[g] = 1'b0;
		end
	end

	// ---------------------------------------------------------------
	// output register
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q <= 1'b0;
		end else if (advance) begin
			s2_valid_q <= s1_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			relay_out_s2 <= relay_out_n;
			active_s2    <= (phase_n != PH_IDLE);
			complete_s2  <= complete_n;
			error_s2     <= error_n;
		end
	end

	assign res.valid          = s2_valid_q;
	assign res.relay_outputs  = relay_out_s2;
	assign res.frame_active   = active_s2;
	assign res.frame_complete = complete_s2;
	assign res.frame_error    = error_s2;

	// ---------------------------------------------------------------
	// assertions
	// ---------------------------------------------------------------
	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> !(res.frame_complete && res.frame_error))
		else $error("frame complete and frame error together");

	a_end_goes_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && (res.frame_complete || res.frame_error) |-> !res.frame_active)
		else $error("frame end result still shows activity");

	a_relay_only_on_tail: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(relay_q) |-> $past(step_en && phase_q == PH_TAIL))
		else $error("relays changed outside a frame tail");

	a_stalled_item_kept: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !advance |=> s1_valid_q && $stable(rx_byte_s1))
		else $error("stalled character lost");

endmodule
